FILE: design/cnti_pkg.sv
// shared types and constants for the chinese numeral to integer block
package cnti_pkg;

  localparam int MAX_CHARS_DEF   = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // magnitude limit is 2^63-1, so magnitudes live in 63 bits
  localparam int MAG_W = 63;

  typedef enum logic [2:0] {
    CLS_NONE,
    CLS_MINUS,
    CLS_POINT,
    CLS_DIGIT,
    CLS_TEN,
    CLS_HUNDRED,
    CLS_LARGE,
    CLS_UNKNOWN
  } cls_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_UNKNOWN,
    ST_ORDER,
    ST_MINUS,
    ST_LONG,
    ST_OVERFLOW
  } status_t;

  // small unit selectors carried in arg
  localparam logic [3:0] UNIT_TEN      = 4'd0;
  localparam logic [3:0] UNIT_HUNDRED  = 4'd1;
  localparam logic [3:0] UNIT_THOUSAND = 4'd2;

  // one classified character
  // arg: digit value, small unit selector, or large unit index 1..4
  typedef struct packed {
    cls_t       cls;
    logic [3:0] arg;
    logic       last;
    logic       first;
    logic       too_long;
  } entry_t;

endpackage

FILE: design/cnti_front.sv
// front end: classifies each code point and tracks the word's character count
module cnti_front #(
  parameter int MAX_CHARS = cnti_pkg::MAX_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [20:0]       in_code_point,
  input  logic              in_last,
  input  logic              q_full,
  output logic              q_push,
  output cnti_pkg::entry_t  q_entry
);

  localparam int CNT_W = $clog2(MAX_CHARS + 1);

  localparam logic [20:0] CP_ZERO     = 21'h096F6;
  localparam logic [20:0] CP_ONE      = 21'h04E00;
  localparam logic [20:0] CP_TWO      = 21'h04E8C;
  localparam logic [20:0] CP_THREE    = 21'h04E09;
  localparam logic [20:0] CP_FOUR     = 21'h056DB;
  localparam logic [20:0] CP_FIVE     = 21'h04E94;
  localparam logic [20:0] CP_SIX      = 21'h0516D;
  localparam logic [20:0] CP_SEVEN    = 21'h04E03;
  localparam logic [20:0] CP_EIGHT    = 21'h0516B;
  localparam logic [20:0] CP_NINE     = 21'h04E5D;
  localparam logic [20:0] CP_TEN      = 21'h05341;
  localparam logic [20:0] CP_HUNDRED  = 21'h0767E;
  localparam logic [20:0] CP_THOUSAND = 21'h05343;
  localparam logic [20:0] CP_WAN      = 21'h04E07;
  localparam logic [20:0] CP_YI       = 21'h04EBF;
  localparam logic [20:0] CP_ZHAO     = 21'h05146;
  localparam logic [20:0] CP_JING     = 21'h04EAC;
  localparam logic [20:0] CP_MINUS    = 21'h08D1F;
  localparam logic [20:0] CP_POINT    = 21'h070B9;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  cnti_pkg::cls_t   cls;
  logic [3:0]       arg;

  always_comb begin
    cls = cnti_pkg::CLS_DIGIT;
    arg = 4'd0;
    unique case (in_code_point)
      CP_ZERO:     arg = 4'd0;
      CP_ONE:      arg = 4'd1;
      CP_TWO:      arg = 4'd2;
      CP_THREE:    arg = 4'd3;
      CP_FOUR:     arg = 4'd4;
      CP_FIVE:     arg = 4'd5;
      CP_SIX:      arg = 4'd6;
      CP_SEVEN:    arg = 4'd7;
      CP_EIGHT:    arg = 4'd8;
      CP_NINE:     arg = 4'd9;
      CP_TEN: begin
        cls = cnti_pkg::CLS_TEN;
        arg = cnti_pkg::UNIT_TEN;
      end
      CP_HUNDRED: begin
        cls = cnti_pkg::CLS_HUNDRED;
        arg = cnti_pkg::UNIT_HUNDRED;
      end
      CP_THOUSAND: begin
        cls = cnti_pkg::CLS_HUNDRED;
        arg = cnti_pkg::UNIT_THOUSAND;
      end
      CP_WAN: begin
        cls = cnti_pkg::CLS_LARGE;
        arg = 4'd1;
      end
      CP_YI: begin
        cls = cnti_pkg::CLS_LARGE;
        arg = 4'd2;
      end
      CP_ZHAO: begin
        cls = cnti_pkg::CLS_LARGE;
        arg = 4'd3;
      end
      CP_JING: begin
        cls = cnti_pkg::CLS_LARGE;
        arg = 4'd4;
      end
      CP_MINUS:    cls = cnti_pkg::CLS_MINUS;
      CP_POINT:    cls = cnti_pkg::CLS_POINT;
      default:     cls = cnti_pkg::CLS_UNKNOWN;
    endcase
  end

  assign q_push = in_push && !q_full;

  always_comb begin
    q_entry.cls      = cls;
    q_entry.arg      = arg;
    q_entry.last     = in_last;
    q_entry.first    = (cnt_r == '0);
    // count saturates at the limit, so reaching it means this beat is one too many
    q_entry.too_long = (cnt_r == CNT_W'(MAX_CHARS));
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      if (in_last) begin
        cnt_nxt = '0;
      end else if (cnt_r != CNT_W'(MAX_CHARS)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: design/cnti_fifo.sv
// short queue of classified characters between front and back end
module cnti_fifo #(
  parameter int DEPTH = cnti_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  cnti_pkg::entry_t  wr_data,
  input  logic              rd_en,
  output cnti_pkg::entry_t  rd_data,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cnti_pkg::entry_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: design/cnti_back.sv
// back end: accumulates sections and totals, scales by large units, emits results
module cnti_back #(
  parameter int MAX_CHARS = cnti_pkg::MAX_CHARS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  cnti_pkg::entry_t  q_entry,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [63:0]       out_value,
  output logic [2:0]        out_status
);

  localparam int MAG_W  = cnti_pkg::MAG_W;
  // each character adds at most 9000 to a section
  localparam int SEC_W  = $clog2(MAX_CHARS * 9000 + 1);
  localparam int G_W    = SEC_W + 1;
  localparam int PROD_W = MAG_W + 14;

  typedef enum logic [2:0] {
    S_RUN,
    S_MUL,
    S_ACC,
    S_SUM,
    S_EMIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [MAG_W-1:0]    total_r, total_nxt;
  logic [SEC_W-1:0]    sec_r, sec_nxt;
  logic [3:0]          pend_r, pend_nxt;
  logic [2:0]          large_r, large_nxt;
  cnti_pkg::cls_t      prev_r, prev_nxt;
  logic                neg_r, neg_nxt;
  cnti_pkg::status_t   err_r, err_nxt;
  logic [MAG_W-1:0]    acc_r, acc_nxt;
  logic [2:0]          k_r, k_nxt;
  logic                rise_r, rise_nxt;
  logic                last_r, last_nxt;
  logic                out_v_r, out_v_nxt;
  logic [63:0]         out_value_r, out_value_nxt;
  logic [2:0]          out_status_r, out_status_nxt;

  logic [13:0]         unit_val;
  logic [13:0]         unit_t;
  logic [3:0]          pend_eff;
  logic [G_W-1:0]      g_raw, g;
  logic                rising;
  logic [63:0]         tg_sum;
  logic [PROD_W-1:0]   acc_w, prod;
  logic [63:0]         acc_sum;
  logic [63:0]         fin_sum;
  logic [63:0]         mag64;

  always_comb begin
    unique case (q_entry.arg)
      cnti_pkg::UNIT_TEN:      unit_val = 14'd10;
      cnti_pkg::UNIT_HUNDRED:  unit_val = 14'd100;
      default:                 unit_val = 14'd1000;
    endcase
  end

  assign pend_eff = (pend_r == 4'd0) ? 4'd1 : pend_r;
  assign unit_t   = {10'd0, pend_eff} * unit_val;
  assign g_raw    = {1'b0, sec_r} + G_W'(pend_r);
  assign g        = (g_raw == '0) ? G_W'(1) : g_raw;
  assign rising   = (large_r != 3'd0) && (q_entry.arg[2:0] > large_r);
  assign tg_sum   = {1'b0, total_r} + 64'(g);

  // times 10^4 as shifted adds: 8192 + 1024 + 512 + 256 + 16
  assign acc_w    = PROD_W'(acc_r);
  assign prod     = (acc_w << 13) + (acc_w << 10) + (acc_w << 9) + (acc_w << 8) + (acc_w << 4);
  assign acc_sum  = {1'b0, total_r} + {1'b0, acc_r};
  assign fin_sum  = {1'b0, total_r} + 64'(sec_r) + 64'(pend_r);
  assign mag64    = {1'b0, acc_r};

  assign q_pop      = (state_r == S_RUN) && !q_empty;
  assign out_empty  = !out_v_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    sec_nxt        = sec_r;
    pend_nxt       = pend_r;
    large_nxt      = large_r;
    prev_nxt       = prev_r;
    neg_nxt        = neg_r;
    err_nxt        = err_r;
    acc_nxt        = acc_r;
    k_nxt          = k_r;
    rise_nxt       = rise_r;
    last_nxt       = last_r;
    out_v_nxt      = out_v_r && !out_pop;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      S_RUN: begin
        if (!q_empty) begin
          last_nxt = q_entry.last;
          if (q_entry.last) begin
            state_nxt = S_SUM;
          end
          if (err_r == cnti_pkg::ST_OK) begin
            if (q_entry.too_long) begin
              err_nxt = cnti_pkg::ST_LONG;
            end else begin
              unique case (q_entry.cls)
                cnti_pkg::CLS_UNKNOWN: err_nxt = cnti_pkg::ST_UNKNOWN;
                cnti_pkg::CLS_MINUS: begin
                  if (!q_entry.first) begin
                    err_nxt = cnti_pkg::ST_MINUS;
                  end else begin
                    neg_nxt  = 1'b1;
                    prev_nxt = cnti_pkg::CLS_MINUS;
                  end
                end
                cnti_pkg::CLS_POINT: prev_nxt = cnti_pkg::CLS_POINT;
                cnti_pkg::CLS_DIGIT: begin
                  pend_nxt = q_entry.arg;
                  prev_nxt = cnti_pkg::CLS_DIGIT;
                end
                cnti_pkg::CLS_TEN, cnti_pkg::CLS_HUNDRED: begin
                  if (prev_r == cnti_pkg::CLS_HUNDRED) begin
                    err_nxt = cnti_pkg::ST_ORDER;
                  end else begin
                    sec_nxt  = sec_r + SEC_W'(unit_t);
                    pend_nxt = 4'd0;
                    prev_nxt = q_entry.cls;
                  end
                end
                cnti_pkg::CLS_LARGE: begin
                  if (prev_r == cnti_pkg::CLS_LARGE) begin
                    err_nxt = cnti_pkg::ST_ORDER;
                  end else begin
                    sec_nxt   = '0;
                    pend_nxt  = 4'd0;
                    large_nxt = q_entry.arg[2:0];
                    prev_nxt  = cnti_pkg::CLS_LARGE;
                    k_nxt     = q_entry.arg[2:0];
                    rise_nxt  = rising;
                    if (rising) begin
                      // a rising unit scales everything so far
                      if (tg_sum[63]) begin
                        err_nxt = cnti_pkg::ST_OVERFLOW;
                      end else begin
                        acc_nxt   = tg_sum[MAG_W-1:0];
                        state_nxt = S_MUL;
                      end
                    end else begin
                      acc_nxt   = MAG_W'(g);
                      state_nxt = S_MUL;
                    end
                  end
                end
                default: ;
              endcase
            end
          end
        end
      end
      S_MUL: begin
        k_nxt = k_r - 3'd1;
        if (prod[PROD_W-1:MAG_W] != '0) begin
          err_nxt   = cnti_pkg::ST_OVERFLOW;
          state_nxt = last_r ? S_SUM : S_RUN;
        end else begin
          acc_nxt = prod[MAG_W-1:0];
          if (k_r == 3'd1) begin
            if (rise_r) begin
              total_nxt = prod[MAG_W-1:0];
              state_nxt = last_r ? S_SUM : S_RUN;
            end else begin
              state_nxt = S_ACC;
            end
          end
        end
      end
      S_ACC: begin
        if (acc_sum[63]) begin
          err_nxt = cnti_pkg::ST_OVERFLOW;
        end else begin
          total_nxt = acc_sum[MAG_W-1:0];
        end
        state_nxt = last_r ? S_SUM : S_RUN;
      end
      S_SUM: begin
        if (err_r == cnti_pkg::ST_OK) begin
          if (fin_sum[63]) begin
            err_nxt = cnti_pkg::ST_OVERFLOW;
          end
          acc_nxt = fin_sum[MAG_W-1:0];
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_v_r || out_pop) begin
          out_v_nxt      = 1'b1;
          out_status_nxt = err_r;
          if (err_r != cnti_pkg::ST_OK) begin
            out_value_nxt = 64'd0;
          end else if (neg_r) begin
            out_value_nxt = 64'd0 - mag64;
          end else begin
            out_value_nxt = mag64;
          end
          // word done, back to a clean slate
          total_nxt = '0;
          sec_nxt   = '0;
          pend_nxt  = 4'd0;
          large_nxt = 3'd0;
          prev_nxt  = cnti_pkg::CLS_NONE;
          neg_nxt   = 1'b0;
          err_nxt   = cnti_pkg::ST_OK;
          state_nxt = S_RUN;
        end
      end
      default: state_nxt = S_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_RUN;
      total_r   <= '0;
      sec_r     <= '0;
      pend_r    <= 4'd0;
      large_r   <= 3'd0;
      prev_r    <= cnti_pkg::CLS_NONE;
      neg_r     <= 1'b0;
      err_r     <= cnti_pkg::ST_OK;
      k_r       <= 3'd0;
      rise_r    <= 1'b0;
      last_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      sec_r     <= sec_nxt;
      pend_r    <= pend_nxt;
      large_r   <= large_nxt;
      prev_r    <= prev_nxt;
      neg_r     <= neg_nxt;
      err_r     <= err_nxt;
      k_r       <= k_nxt;
      rise_r    <= rise_nxt;
      last_r    <= last_nxt;
      out_v_r   <= out_v_nxt;
    end
    acc_r        <= acc_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

FILE: design/chinese_numeral_to_integer.sv
// top level of the chinese numeral word to signed integer converter
//
// input channel: one unicode code point per beat on in_code_point, with in_last
// marking the final character of a word; a beat is taken when push is high and
// full is low. result channel: one beat per word (out_value, out_status) is
// shown while empty is low and taken when pop is high.
// the front end classifies a character in the cycle it is pushed and writes it
// into a QUEUE_DEPTH entry queue, so push is accepted every cycle until the
// queue fills. the back end takes one digit, small unit, minus or point per
// cycle while it is in its run state; a large unit makes k passes (k = 1..4) of
// the times-10^4 shift-add unit, plus an add step when it does not scale the
// running total. after the last character the back end forms the final sum and
// then loads the result register.
// if the receiver stalls, the result register holds, the back end waits with
// the next finished word and the queue keeps taking beats until full.
// reset empties the queue and the result register and clears all word state;
// no clearing pass is needed.
module chinese_numeral_to_integer #(
  parameter int MAX_CHARS   = cnti_pkg::MAX_CHARS_DEF,
  parameter int QUEUE_DEPTH = cnti_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [20:0] in_code_point,
  input  logic        in_last,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_value,
  output logic [2:0]  out_status
);

  logic             q_push;
  logic             q_pop;
  logic             q_empty;
  cnti_pkg::entry_t q_wr_entry;
  cnti_pkg::entry_t q_rd_entry;

  cnti_front #(
    .MAX_CHARS (MAX_CHARS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (push),
    .in_code_point (in_code_point),
    .in_last       (in_last),
    .q_full        (full),
    .q_push        (q_push),
    .q_entry       (q_wr_entry)
  );

  cnti_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_entry),
    .rd_en   (q_pop),
    .rd_data (q_rd_entry),
    .full    (full),
    .empty   (q_empty)
  );

  cnti_back #(
    .MAX_CHARS (MAX_CHARS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_entry    (q_rd_entry),
    .q_pop      (q_pop),
    .out_empty  (empty),
    .out_pop    (pop),
    .out_value  (out_value),
    .out_status (out_status)
  );

`ifndef ASSERT_OFF
  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != cnti_pkg::ST_OK) |-> (out_value == 64'd0))
    else $error("nonzero value with error status");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status <= cnti_pkg::ST_OVERFLOW))
    else $error("status code out of range");

  a_reset_clean: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> (empty && !full))
    else $error("queue or result not clear after reset");

  a_queue_drain: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back end popped an empty queue");
`endif

endmodule

FILE: bench/tb_top.sv
// testbench for the chinese numeral to integer converter: directed and random words
`timescale 1ns / 100ps

module tb_top;

  localparam int WORD_MAX = cnti_pkg::MAX_CHARS_DEF;
  localparam logic [63:0] MAG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [20:0] CP_ZERO     = 21'h096F6;
  localparam logic [20:0] CP_ONE      = 21'h04E00;
  localparam logic [20:0] CP_TWO      = 21'h04E8C;
  localparam logic [20:0] CP_THREE    = 21'h04E09;
  localparam logic [20:0] CP_FOUR     = 21'h056DB;
  localparam logic [20:0] CP_FIVE     = 21'h04E94;
  localparam logic [20:0] CP_SIX      = 21'h0516D;
  localparam logic [20:0] CP_SEVEN    = 21'h04E03;
  localparam logic [20:0] CP_EIGHT    = 21'h0516B;
  localparam logic [20:0] CP_NINE     = 21'h04E5D;
  localparam logic [20:0] CP_TEN      = 21'h05341;
  localparam logic [20:0] CP_HUNDRED  = 21'h0767E;
  localparam logic [20:0] CP_THOUSAND = 21'h05343;
  localparam logic [20:0] CP_WAN      = 21'h04E07;
  localparam logic [20:0] CP_YI       = 21'h04EBF;
  localparam logic [20:0] CP_ZHAO     = 21'h05146;
  localparam logic [20:0] CP_JING     = 21'h04EAC;
  localparam logic [20:0] CP_MINUS    = 21'h08D1F;
  localparam logic [20:0] CP_POINT    = 21'h070B9;
  localparam logic [20:0] CP_TOP      = 21'h10FFFF;

  typedef struct {
    logic [63:0]       value;
    cnti_pkg::status_t status;
  } word_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [20:0] in_code_point = '0;
  logic        in_last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] out_value;
  logic [2:0]  out_status;

  int send_idle_pct = 12;
  int recv_idle_pct = 78;
  int error_count = 0;
  int chars_sent = 0;

  word_result_t expected_results[$];
  logic [20:0]  word_buf[$];

  // running state of the word being parsed
  logic [63:0]       word_total;
  logic [63:0]       word_section;
  logic [63:0]       word_digit;
  logic [63:0]       word_large;
  cnti_pkg::cls_t    word_prev;
  logic              word_neg;
  int                word_chars;
  cnti_pkg::status_t word_err;

  chinese_numeral_to_integer u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_code_point (in_code_point),
    .in_last       (in_last),
    .empty         (empty),
    .pop           (pop),
    .out_value     (out_value),
    .out_status    (out_status)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [20:0] digit_cp(input int n);
    case (n)
      0: return CP_ZERO;
      1: return CP_ONE;
      2: return CP_TWO;
      3: return CP_THREE;
      4: return CP_FOUR;
      5: return CP_FIVE;
      6: return CP_SIX;
      7: return CP_SEVEN;
      8: return CP_EIGHT;
      default: return CP_NINE;
    endcase
  endfunction

  function automatic logic [20:0] large_cp(input int idx);
    case (idx)
      1: return CP_WAN;
      2: return CP_YI;
      3: return CP_ZHAO;
      default: return CP_JING;
    endcase
  endfunction

  function automatic logic [63:0] large_scale(input logic [63:0] idx);
    case (idx)
      64'd1: return 64'd10000;
      64'd2: return 64'd100000000;
      64'd3: return 64'd1000000000000;
      64'd4: return 64'd10000000000000000;
      default: return 64'd0;
    endcase
  endfunction

  function automatic logic [20:0] any_symbol(input int sel);
    case (sel)
      10: return CP_TEN;
      11: return CP_HUNDRED;
      12: return CP_THOUSAND;
      13: return CP_WAN;
      14: return CP_YI;
      15: return CP_ZHAO;
      16: return CP_JING;
      17: return CP_MINUS;
      18: return CP_POINT;
      default: return digit_cp(sel);
    endcase
  endfunction

  task automatic classify_char(input logic [20:0] cp, output cnti_pkg::cls_t cls,
                               output logic [63:0] amount);
    cls = cnti_pkg::CLS_DIGIT;
    amount = 64'd0;
    case (cp)
      CP_ZERO:     amount = 64'd0;
      CP_ONE:      amount = 64'd1;
      CP_TWO:      amount = 64'd2;
      CP_THREE:    amount = 64'd3;
      CP_FOUR:     amount = 64'd4;
      CP_FIVE:     amount = 64'd5;
      CP_SIX:      amount = 64'd6;
      CP_SEVEN:    amount = 64'd7;
      CP_EIGHT:    amount = 64'd8;
      CP_NINE:     amount = 64'd9;
      CP_TEN:      begin cls = cnti_pkg::CLS_TEN;     amount = 64'd10;   end
      CP_HUNDRED:  begin cls = cnti_pkg::CLS_HUNDRED; amount = 64'd100;  end
      CP_THOUSAND: begin cls = cnti_pkg::CLS_HUNDRED; amount = 64'd1000; end
      CP_WAN:      begin cls = cnti_pkg::CLS_LARGE;   amount = 64'd1;    end
      CP_YI:       begin cls = cnti_pkg::CLS_LARGE;   amount = 64'd2;    end
      CP_ZHAO:     begin cls = cnti_pkg::CLS_LARGE;   amount = 64'd3;    end
      CP_JING:     begin cls = cnti_pkg::CLS_LARGE;   amount = 64'd4;    end
      CP_MINUS:    cls = cnti_pkg::CLS_MINUS;
      CP_POINT:    cls = cnti_pkg::CLS_POINT;
      default:     cls = cnti_pkg::CLS_UNKNOWN;
    endcase
  endtask

  function automatic logic [63:0] checked_add(input logic [63:0] a, input logic [63:0] b);
    if (a > MAG_LIMIT || b > MAG_LIMIT - a) begin
      if (word_err == cnti_pkg::ST_OK) word_err = cnti_pkg::ST_OVERFLOW;
      return 64'd0;
    end
    return a + b;
  endfunction

  function automatic logic [63:0] checked_mul(input logic [63:0] a, input logic [63:0] b);
    if (b != 64'd0 && a > MAG_LIMIT / b) begin
      if (word_err == cnti_pkg::ST_OK) word_err = cnti_pkg::ST_OVERFLOW;
      return 64'd0;
    end
    return a * b;
  endfunction

  task automatic clear_word();
    word_total = 64'd0;
    word_section = 64'd0;
    word_digit = 64'd0;
    word_large = 64'd0;
    word_prev = cnti_pkg::CLS_NONE;
    word_neg = 1'b0;
    word_chars = 0;
    word_err = cnti_pkg::ST_OK;
  endtask

  // update the word state with one accepted character; a last beat yields the result
  task automatic parse_char(input logic [20:0] cp, input logic lst);
    cnti_pkg::cls_t cls;
    logic [63:0]    amount;
    logic [63:0]    grp;
    logic [63:0]    acc;
    word_result_t   res;
    classify_char(cp, cls, amount);
    if (word_chars <= WORD_MAX) word_chars++;
    if (word_err == cnti_pkg::ST_OK) begin
      if (word_chars > WORD_MAX) begin
        word_err = cnti_pkg::ST_LONG;
      end else begin
        case (cls)
          cnti_pkg::CLS_UNKNOWN: word_err = cnti_pkg::ST_UNKNOWN;
          cnti_pkg::CLS_MINUS: begin
            if (word_chars != 1) word_err = cnti_pkg::ST_MINUS;
            else word_neg = 1'b1;
          end
          cnti_pkg::CLS_DIGIT: word_digit = amount;
          cnti_pkg::CLS_TEN, cnti_pkg::CLS_HUNDRED: begin
            if (word_prev == cnti_pkg::CLS_HUNDRED) begin
              word_err = cnti_pkg::ST_ORDER;
            end else begin
              acc = checked_mul((word_digit == 64'd0) ? 64'd1 : word_digit, amount);
              word_section = checked_add(word_section, acc);
              word_digit = 64'd0;
            end
          end
          cnti_pkg::CLS_LARGE: begin
            if (word_prev == cnti_pkg::CLS_LARGE) begin
              word_err = cnti_pkg::ST_ORDER;
            end else begin
              grp = checked_add(word_section, word_digit);
              if (grp == 64'd0) grp = 64'd1;
              // a higher large unit scales everything gathered so far
              if (word_large != 64'd0 && amount > word_large) begin
                acc = checked_add(word_total, grp);
                word_total = checked_mul(acc, large_scale(amount));
              end else begin
                acc = checked_mul(grp, large_scale(amount));
                word_total = checked_add(word_total, acc);
              end
              word_section = 64'd0;
              word_digit = 64'd0;
              word_large = amount;
            end
          end
          default: ;
        endcase
        word_prev = cls;
      end
    end
    if (lst) begin
      res.value = 64'd0;
      if (word_err == cnti_pkg::ST_OK) begin
        acc = checked_add(word_total, word_section);
        acc = checked_add(acc, word_digit);
        if (word_err == cnti_pkg::ST_OK) res.value = word_neg ? (64'd0 - acc) : acc;
      end
      res.status = word_err;
      expected_results.push_back(res);
      clear_word();
    end
  endtask

  // drive one beat; returns just after the edge that took it
  task automatic send_char(input logic [20:0] cp, input logic lst);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_code_point <= cp;
    in_last <= lst;
    @(posedge clk);
    while (full !== 1'b0) @(posedge clk);
    parse_char(cp, lst);
    chars_sent++;
  endtask

  task automatic send_word();
    for (int i = 0; i < word_buf.size(); i++) send_char(word_buf[i], i == word_buf.size() - 1);
  endtask

  task automatic add_section();
    logic started;
    started = 1'b0;
    if ($urandom_range(1)) begin
      word_buf.push_back(digit_cp($urandom_range(1, 9)));
      word_buf.push_back(CP_THOUSAND);
      started = 1'b1;
    end
    if ($urandom_range(1)) begin
      word_buf.push_back(digit_cp($urandom_range(1, 9)));
      word_buf.push_back(CP_HUNDRED);
      started = 1'b1;
    end
    if ($urandom_range(1)) begin
      if (started || $urandom_range(1)) word_buf.push_back(digit_cp($urandom_range(1, 9)));
      word_buf.push_back(CP_TEN);
      started = 1'b1;
    end
    if ($urandom_range(1)) begin
      if (started && $urandom_range(2) == 0) word_buf.push_back(CP_ZERO);
      word_buf.push_back(digit_cp($urandom_range(0, 9)));
    end
  endtask

  task automatic build_numeral();
    int groups;
    int unit;
    int base;
    if ($urandom_range(4) == 0) word_buf.push_back(CP_MINUS);
    base = word_buf.size();
    groups = $urandom_range(0, 3);
    unit = $urandom_range(1, 4);
    repeat (groups) begin
      add_section();
      word_buf.push_back(large_cp(unit));
      if ($urandom_range(9) == 0) word_buf.push_back(CP_POINT);
      // mostly falling units, sometimes rising or repeated
      if (unit > 1 && $urandom_range(9) < 8) unit = $urandom_range(1, unit - 1);
      else unit = $urandom_range(1, 4);
    end
    if (groups == 0 || $urandom_range(1)) add_section();
    if (word_buf.size() == base) word_buf.push_back(digit_cp($urandom_range(0, 9)));
  endtask

  task automatic build_random_word();
    int kind;
    kind = $urandom_range(99);
    word_buf.delete();
    if (kind < 72) begin
      build_numeral();
    end else if (kind < 86) begin
      repeat ($urandom_range(1, 8)) word_buf.push_back(any_symbol($urandom_range(0, 18)));
    end else begin
      // broken numeral: one character swapped for an arbitrary code point
      build_numeral();
      word_buf[$urandom_range(0, word_buf.size() - 1)] = 21'($urandom_range(0, CP_TOP));
    end
  endtask

  task automatic test_signs_and_empty();
    word_buf = '{CP_MINUS};
    send_word();
    word_buf = '{CP_POINT};
    send_word();
    word_buf = '{CP_MINUS, CP_TWO, CP_THOUSAND, CP_ZERO, CP_FIVE};
    send_word();
    word_buf = '{CP_ONE, CP_MINUS};
    send_word();
  endtask

  task automatic test_digits_and_small_units();
    word_buf = '{CP_THREE, CP_SEVEN};
    send_word();
    word_buf = '{CP_TEN, CP_TEN};
    send_word();
    word_buf = '{CP_HUNDRED, CP_TEN};
    send_word();
  endtask

  task automatic test_large_units();
    word_buf = '{CP_WAN, CP_YI};
    send_word();
    word_buf = '{CP_ONE, CP_WAN, CP_ONE, CP_YI};
    send_word();
    word_buf = '{CP_NINE, CP_THOUSAND, CP_JING};
    send_word();
    word_buf = '{CP_ZHAO};
    send_word();
  endtask

  task automatic test_bad_chars();
    word_buf = '{CP_TOP, CP_MINUS};
    send_word();
    word_buf = '{21'h0};
    send_word();
  endtask

  task automatic test_word_length();
    for (int len = WORD_MAX - 1; len <= WORD_MAX + 2; len++) begin
      word_buf.delete();
      if ($urandom_range(1)) word_buf.push_back(CP_MINUS);
      while (word_buf.size() < len) word_buf.push_back(digit_cp($urandom_range(0, 9)));
      send_word();
    end
  endtask

  task automatic test_random_words(input int count);
    int target;
    target = chars_sent + count;
    while (chars_sent < target) begin
      build_random_word();
      send_word();
    end
  endtask

  always @(negedge clk) pop <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin : check_results
    word_result_t want;
    if (rst_n && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d status %0d",
                                  $signed(out_value), out_status));
      end else begin
        want = expected_results.pop_front();
        if (out_value !== want.value)
          report_mismatch($sformatf("value %0d, expected %0d",
                                    $signed(out_value), $signed(want.value)));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
      end
    end
  end

  initial begin : main_sequence
    int drain_cycles;
    clear_word();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_signs_and_empty();
    test_digits_and_small_units();
    test_large_units();
    test_bad_chars();
    test_word_length();
    test_random_words(380);

    send_idle_pct = 78;
    recv_idle_pct = 12;
    test_random_words(380);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_words(380);

    @(negedge clk);
    push <= 1'b0;
    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (60) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
